// ===== hw/rtl/ssdw_pkg.sv =====
`default_nettype none
package ssdw_pkg;

  localparam int NUM_POSITIONS = 7;

  // request codes
  typedef enum logic [1:0] {
    OP_DIGIT    = 2'd0,
    OP_RAW      = 2'd1,
    OP_CONTROL  = 2'd2,
    OP_AUTO_INC = 2'd3
  } op_t;

  // driver command bytes
  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] CMD_ADDR       = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY    = 8'h80;
  localparam logic [7:0] CMD_AUTO_INC   = 8'h40;

  localparam int RUN_BITS  = 24;
  localparam int IDX_W     = $clog2(RUN_BITS);
  localparam int QUEUE_DEPTH = 2;

  // one classified word: bytes packed LSB-first send order
  typedef struct packed {
    logic [RUN_BITS-1:0] bits;
    logic                is_long;   // 1: three bytes in two frames, 0: one byte
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } push_t;

  // blank for 10-15
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'b00111111;
      4'd1:    pat = 8'b00000110;
      4'd2:    pat = 8'b01011011;
      4'd3:    pat = 8'b01001111;
      4'd4:    pat = 8'b01100110;
      4'd5:    pat = 8'b01101101;
      4'd6:    pat = 8'b01111101;
      4'd7:    pat = 8'b00000111;
      4'd8:    pat = 8'b01111111;
      4'd9:    pat = 8'b01101111;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssdw_front.sv =====
`default_nettype none
module ssdw_front (
  input  wire logic       accept,
  input  wire logic [1:0] op,
  input  wire logic [2:0] position,
  input  wire logic [3:0] digit_value,
  input  wire logic       show_dot,
  input  wire logic [7:0] raw_segments,
  input  wire logic       display_on,
  input  wire logic [3:0] intensity,
  output ssdw_pkg::push_t push_bus
);

  logic [7:0] pattern;
  logic [7:0] addr_byte;
  logic [2:0] level;
  logic       pos_ok;

  always_comb begin
    pattern   = (ssdw_pkg::op_t'(op) == ssdw_pkg::OP_DIGIT) ?
                (ssdw_pkg::seg_pattern(digit_value) | {show_dot, 7'd0}) : raw_segments;
    addr_byte = ssdw_pkg::CMD_ADDR | {4'd0, position, 1'b0};
    level     = intensity[3] ? 3'd7 : intensity[2:0];
    pos_ok    = ({1'b0, position} < 4'(ssdw_pkg::NUM_POSITIONS));

    push_bus.push = 1'b0;
    push_bus.desc = '0;
    unique case (ssdw_pkg::op_t'(op))
      ssdw_pkg::OP_DIGIT, ssdw_pkg::OP_RAW: begin
        // out-of-range position drops the request
        push_bus.push         = accept && pos_ok;
        push_bus.desc.bits    = {pattern, addr_byte, ssdw_pkg::CMD_FIXED_ADDR};
        push_bus.desc.is_long = 1'b1;
      end
      ssdw_pkg::OP_CONTROL: begin
        push_bus.push      = accept;
        push_bus.desc.bits = {16'd0, ssdw_pkg::CMD_DISPLAY | {4'd0, display_on, level}};
      end
      ssdw_pkg::OP_AUTO_INC: begin
        push_bus.push      = accept;
        push_bus.desc.bits = {16'd0, ssdw_pkg::CMD_AUTO_INC};
      end
      default: begin
        push_bus.push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssdw_queue.sv =====
`default_nettype none
module ssdw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ssdw_pkg::push_t push_bus,
  input  wire logic          pop,
  output ssdw_pkg::desc_t    head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = $clog2(ssdw_pkg::QUEUE_DEPTH);

  ssdw_pkg::desc_t mem [ssdw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  logic do_push;
  logic do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (PTR_W+1)'(ssdw_pkg::QUEUE_DEPTH));
  assign do_push = push_bus.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_bus.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssdw_back.sv =====
`default_nettype none
module ssdw_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ssdw_pkg::desc_t head,
  input  wire logic        empty,
  output logic             pop,
  output logic             result_strobe,
  output logic             bit_value,
  output logic             frame_start,
  output logic             frame_end,
  output logic             last
);

  localparam logic [ssdw_pkg::IDX_W-1:0] IDX_BYTE_END  = ssdw_pkg::IDX_W'(7);
  localparam logic [ssdw_pkg::IDX_W-1:0] IDX_FRAME2    = ssdw_pkg::IDX_W'(8);
  localparam logic [ssdw_pkg::IDX_W-1:0] IDX_LONG_END  =
    ssdw_pkg::IDX_W'(ssdw_pkg::RUN_BITS - 1);

  logic                         active;
  logic [ssdw_pkg::RUN_BITS-1:0] shreg;
  logic                         is_long;
  logic [ssdw_pkg::IDX_W-1:0]   idx;

  always_comb begin
    result_strobe = active;
    bit_value     = shreg[0];
    frame_start   = active && ((idx == '0) || (is_long && (idx == IDX_FRAME2)));
    frame_end     = active && ((idx == IDX_BYTE_END) || (is_long && (idx == IDX_LONG_END)));
    last          = active && (idx == (is_long ? IDX_LONG_END : IDX_BYTE_END));
    pop           = !empty && (!active || last);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg   <= head.bits;
      is_long <= head.is_long;
    end else begin
      shreg   <= {1'b0, shreg[ssdw_pkg::RUN_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (last) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (active) begin
      idx    <= idx + 1'b1;
    end
  end

  a_last_closes_frame: assert property (@(posedge clk) disable iff (rst)
    last |-> frame_end) else $error("final bit without frame end");

  a_second_frame_follows: assert property (@(posedge clk) disable iff (rst)
    frame_end && !last |=> result_strobe && frame_start)
    else $error("second frame did not follow first");

  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe) else $error("bit run broken");

  a_no_marker_idle: assert property (@(posedge clk) disable iff (rst)
    !result_strobe |-> !(frame_start || frame_end || last))
    else $error("marker without strobe");

endmodule
`default_nettype wire

// ===== hw/rtl/seven_segment_serial_display_writer.sv =====
`default_nettype none
// Serial writer for a three-wire seven-segment LED driver. A request word is
// taken at a clock edge with start high and busy low; it becomes a run of
// bits, LSB first, one result per cycle on result_strobe, and the receiver
// must take each bit in the cycle it appears (there is no stall). Digit and
// raw writes send 24 bits (a fixed-address command frame, then an address
// and segment frame); display control and mode send 8 bits. The serializer
// shifts one bit per clock. Requests with a position outside the display
// are dropped and produce no bits. A two-word queue sits between the
// classifier and the serializer, so busy only rises when two words wait
// behind the run in progress. With the serializer idle, an accepted word is
// first written into the queue and then loaded into the serializer's shift
// register, and only then is its first bit on the line.
module seven_segment_serial_display_writer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [2:0] position,
  input  wire logic [3:0] digit_value,
  input  wire logic       show_dot,
  input  wire logic [7:0] raw_segments,
  input  wire logic       display_on,
  input  wire logic [3:0] intensity,
  output logic            result_strobe,
  output logic            bit_value,
  output logic            frame_start,
  output logic            frame_end,
  output logic            last
);

  ssdw_pkg::push_t push_bus;
  ssdw_pkg::desc_t head;
  logic            empty;
  logic            full;
  logic            pop;
  logic            accept;

  // word accepted only while the queue has room
  assign busy   = full;
  assign accept = start && !full;

  // classify request into a byte run
  ssdw_front u_front (
    .accept       (accept),
    .op           (op),
    .position     (position),
    .digit_value  (digit_value),
    .show_dot     (show_dot),
    .raw_segments (raw_segments),
    .display_on   (display_on),
    .intensity    (intensity),
    .push_bus     (push_bus)
  );

  ssdw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_bus (push_bus),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // shift out, one bit per clock, markers from the bit index
  ssdw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .result_strobe (result_strobe),
    .bit_value     (bit_value),
    .frame_start   (frame_start),
    .frame_end     (frame_end),
    .last          (last)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  // Sender stalls are short random gaps; the block never
  // holds more than three words, so a long silence means it hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 285;
  localparam int DRAIN_CYCLES   = 40;

  // one request word, field by field as the ports carry it
  typedef struct packed {
    ssdw_pkg::op_t op;
    logic [2:0]    position;
    logic [3:0]    digit_value;
    logic          show_dot;
    logic [7:0]    raw_segments;
    logic          display_on;
    logic [3:0]    intensity;
  } request_t;

  // one bit on the serial line, with its strobe markers
  typedef struct packed {
    logic bit_value;
    logic frame_start;
    logic frame_end;
    logic last;
  } line_bit_t;

  // directed row: the run is typed in only when known_run is set
  typedef struct {
    request_t    req;
    bit          known_run;
    logic [23:0] run;
    int          nbits;
  } stim_row_t;

  // segment codes for 0-9, bit 0 is segment a
  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  ssdw_pkg::op_t op = ssdw_pkg::OP_DIGIT;
  logic [2:0]    position = '0;
  logic [3:0]    digit_value = '0;
  logic          show_dot = 1'b0;
  logic [7:0]    raw_segments = '0;
  logic          display_on = 1'b0;
  logic [3:0]    intensity = '0;
  logic          busy;
  logic          result_strobe;
  logic          bit_value;
  logic          frame_start;
  logic          frame_end;
  logic          last;

  seven_segment_serial_display_writer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .position     (position),
    .digit_value  (digit_value),
    .show_dot     (show_dot),
    .raw_segments (raw_segments),
    .display_on   (display_on),
    .intensity    (intensity),
    .result_strobe(result_strobe),
    .bit_value    (bit_value),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .last         (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bits still owed by the block, oldest first
  line_bit_t   pending_bits[$];
  int unsigned mismatches = 0;
  int unsigned bits_checked = 0;
  int unsigned words_dropped = 0;
  int unsigned words_by_op[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // Serial run for one word, packed in send order (first bit in bit 0).
  // nbits is 0 when the word is dropped for a bad position.
  function automatic void serial_run_for(input request_t r, output logic [23:0] run,
                                         output int nbits);
    logic [7:0] pattern;
    logic [2:0] level;
    run = '0;
    nbits = 0;
    case (r.op)
      ssdw_pkg::OP_DIGIT, ssdw_pkg::OP_RAW: begin
        if (r.position < ssdw_pkg::NUM_POSITIONS) begin
          if (r.op == ssdw_pkg::OP_DIGIT) begin
            // 10-15 blank, dot still ORed in
            pattern = (r.digit_value <= 4'd9) ? DIGIT_SEGS[r.digit_value] : 8'h00;
            pattern[7] = pattern[7] | r.show_dot;
          end else begin
            pattern = r.raw_segments;
          end
          run = {pattern, ssdw_pkg::CMD_ADDR | {4'd0, r.position, 1'b0},
                 ssdw_pkg::CMD_FIXED_ADDR};
          nbits = 24;
        end
      end
      ssdw_pkg::OP_CONTROL: begin
        level = (r.intensity > 4'd7) ? 3'd7 : r.intensity[2:0];
        run = {16'd0, ssdw_pkg::CMD_DISPLAY | {4'd0, r.display_on, level}};
        nbits = 8;
      end
      default: begin
        run = {16'd0, ssdw_pkg::CMD_AUTO_INC};
        nbits = 8;
      end
    endcase
  endfunction

  // A 24-bit run is a one-byte frame then a two-byte frame; an 8-bit run
  // is a single frame.
  function automatic void queue_run(input logic [23:0] run, input int nbits);
    line_bit_t b;
    for (int i = 0; i < nbits; i++) begin
      b.bit_value   = run[i];
      b.frame_start = (i == 0) || (nbits == 24 && i == 8);
      b.frame_end   = (i == nbits - 1) || (nbits == 24 && i == 7);
      b.last        = (i == nbits - 1);
      pending_bits.push_back(b);
    end
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      flag_mismatch($sformatf("serial bit %0d: %s got %b want %b",
                              bits_checked, name, got, want));
  endtask

  // Output side: every strobed bit must match the oldest pending one.
  always @(posedge clk) begin : line_check
    line_bit_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (pending_bits.size() == 0) begin
        flag_mismatch($sformatf("unexpected bit %b start %b end %b last %b",
                                bit_value, frame_start, frame_end, last));
      end else begin
        want = pending_bits.pop_front();
        check_field("bit_value", bit_value, want.bit_value);
        check_field("frame_start", frame_start, want.frame_start);
        check_field("frame_end", frame_end, want.frame_end);
        check_field("last", last, want.last);
        bits_checked++;
      end
    end
  end

  // Watchdog: any accepted word or strobed bit counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles, %0d bits still pending",
               WATCHDOG_LIMIT, pending_bits.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic stim_row_t make_row(input ssdw_pkg::op_t o, input logic [2:0] p,
                                         input logic [3:0] d, input logic dot,
                                         input logic [7:0] raw, input logic on,
                                         input logic [3:0] inten,
                                         input logic [23:0] run = '0,
                                         input int nbits = -1);
    stim_row_t row;
    row.req = '{o, p, d, dot, raw, on, inten};
    row.known_run = (nbits >= 0);
    row.run = run;
    row.nbits = nbits;
    return row;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op           = ssdw_pkg::op_t'($urandom_range(3));
    // mostly valid positions; an occasional 7 exercises the drop path
    r.position     = ($urandom_range(11) == 0) ? 3'd7 : 3'($urandom_range(6));
    r.digit_value  = 4'($urandom);
    r.show_dot     = 1'($urandom);
    r.raw_segments = 8'($urandom);
    r.display_on   = 1'($urandom);
    r.intensity    = 4'($urandom);
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the word was taken,
  // leaving start high so the next word can follow back to back.
  task automatic send_word(input request_t r, input bit known_run,
                           input logic [23:0] run, input int nbits);
    logic [23:0] want_run;
    int          want_n;
    start        <= 1'b1;
    op           <= r.op;
    position     <= r.position;
    digit_value  <= r.digit_value;
    show_dot     <= r.show_dot;
    raw_segments <= r.raw_segments;
    display_on   <= r.display_on;
    intensity    <= r.intensity;
    do @(posedge clk); while (busy !== 1'b0);
    if (known_run) begin
      want_run = run;
      want_n = nbits;
    end else begin
      serial_run_for(r, want_run, want_n);
    end
    queue_run(want_run, want_n);
    words_by_op[r.op]++;
    if (want_n == 0)
      words_dropped++;
  endtask

  // random sender idle gaps; each further idle cycle has a 15 in 100 chance
  task automatic sender_gap(input bit allowed);
    if (allowed) begin
      while ($urandom_range(99) < 15) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // hold off until the block has sent every owed bit
  task automatic wait_line_empty();
    start <= 1'b0;
    do @(posedge clk); while (pending_bits.size() != 0);
  endtask

  initial begin
    stim_row_t rows[$];
    request_t  r;
    int        k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // mode word; unused fields must not leak in
    rows.push_back(make_row(ssdw_pkg::OP_AUTO_INC, 3'd0, 4'd0, 1'b0, 8'h00, 1'b0, 4'd0,
                            24'h000040, 8));
    rows.push_back(make_row(ssdw_pkg::OP_AUTO_INC, 3'd7, 4'd15, 1'b1, 8'hFF, 1'b1, 4'd15,
                            24'h000040, 8));
    // display control: off/min, on with saturated brightness
    rows.push_back(make_row(ssdw_pkg::OP_CONTROL, 3'd0, 4'd0, 1'b0, 8'h00, 1'b0, 4'd0,
                            24'h000080, 8));
    rows.push_back(make_row(ssdw_pkg::OP_CONTROL, 3'd0, 4'd0, 1'b0, 8'h00, 1'b1, 4'd15,
                            24'h00008F, 8));
    rows.push_back(make_row(ssdw_pkg::OP_CONTROL, 3'd7, 4'd15, 1'b1, 8'hFF, 1'b0, 4'd7,
                            24'h000087, 8));
    rows.push_back(make_row(ssdw_pkg::OP_CONTROL, 3'd3, 4'd0, 1'b0, 8'h00, 1'b1, 4'd8,
                            24'h00008F, 8));
    // digit writes at position extremes
    rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'd0, 4'd0, 1'b0, 8'h00, 1'b0, 4'd0,
                            24'h3FC044, 24));
    rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'd6, 4'd8, 1'b1, 8'h00, 1'b0, 4'd0,
                            24'hFFCC44, 24));
    // digits past nine go blank, dot still shows
    rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'd3, 4'd15, 1'b0, 8'hFF, 1'b1, 4'd15,
                            24'h00C644, 24));
    rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'd2, 4'd10, 1'b1, 8'h00, 1'b0, 4'd0,
                            24'h80C444, 24));
    // position off the display: dropped, no bits
    rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'd7, 4'd5, 1'b0, 8'h00, 1'b0, 4'd0,
                            24'h000000, 0));
    rows.push_back(make_row(ssdw_pkg::OP_RAW, 3'd7, 4'd0, 1'b0, 8'hFF, 1'b0, 4'd0,
                            24'h000000, 0));
    // raw zero clears, raw all-ones
    rows.push_back(make_row(ssdw_pkg::OP_RAW, 3'd0, 4'd0, 1'b0, 8'h00, 1'b0, 4'd0,
                            24'h00C044, 24));
    rows.push_back(make_row(ssdw_pkg::OP_RAW, 3'd6, 4'd15, 1'b1, 8'hFF, 1'b1, 4'd15,
                            24'hFFCC44, 24));
    rows.push_back(make_row(ssdw_pkg::OP_RAW, 3'd5, 4'd0, 1'b0, 8'hA5, 1'b0, 4'd0));
    rows.push_back(make_row(ssdw_pkg::OP_RAW, 3'd4, 4'd9, 1'b1, 8'h5A, 1'b1, 4'd3));
    // rest of the digit table, junk in the unused fields
    for (int d = 1; d <= 9; d++)
      rows.push_back(make_row(ssdw_pkg::OP_DIGIT, 3'(d % 7), 4'(d), 1'(d), ~8'(d), 1'b1,
                              4'(d)));

    foreach (rows[i]) begin
      sender_gap(1'b1);
      send_word(rows[i].req, rows[i].known_run, rows[i].run, rows[i].nbits);
    end

    // let the line go idle once before the random traffic
    wait_line_empty();

    // Random words; words 120-199 go back to back.
    k = 0;
    while (k < RANDOM_WORDS) begin
      r = random_request();
      if (k == 250)
        wait_line_empty();
      sender_gap(k < 120 || k >= 200);
      send_word(r, 1'b0, '0, 0);
      k++;
    end

    wait_line_empty();
    // anything strobed after this is flagged by the line check
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("words sent: %0d digit, %0d raw, %0d control, %0d mode (%0d dropped)",
             words_by_op[ssdw_pkg::OP_DIGIT], words_by_op[ssdw_pkg::OP_RAW],
             words_by_op[ssdw_pkg::OP_CONTROL], words_by_op[ssdw_pkg::OP_AUTO_INC],
             words_dropped);
    $display("serial bits compared: %0d, mismatches: %0d", bits_checked, mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
